// File: design/ctes_pkg.sv
// shared constants and calendar tables for the calendar to epoch seconds converter
package ctes_pkg;

	localparam int unsigned DaysW  = 16;
	localparam int unsigned TodW   = 17;
	localparam int unsigned ZoneW  = 17;
	localparam int unsigned EpochW = 32;

	localparam logic [TodW-1:0]  SecsPerDay   = 17'd86400;
	localparam logic [ZoneW-1:0] ZoneReset    = 17'd28800;
	// years from 1970 to 2000
	localparam logic [7:0]       YearsToBase  = 8'd30;
	// leap years 1972 through 1996
	localparam logic [DaysW-1:0] LeapsToBase  = 16'd7;
	// the only century in range that is not a leap year (2100)
	localparam logic [6:0]       NonLeapCent  = 7'd100;

	localparam logic [3:0] MonthJan = 4'd1;
	localparam logic [3:0] MonthFeb = 4'd2;
	localparam logic [3:0] MonthDec = 4'd12;

	// days in the year before the first of the given month
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: design/calendar_to_epoch_seconds.sv
// calendar reading to epoch seconds converter, three stage pipeline
// Converts a calendar reading (year 2000 plus year_in_century, month, day, hour, minute,
// second) into seconds since 1970-01-01 00:00:00 minus the signed zone offset, modulo 2^32.
// The block takes one request per cycle while the output is not stalled; every accepted
// request then passes through the three register stages, in order the day count
// and time of day, the 16 by 17 bit day-to-seconds multiply, and the final add and offset
// subtract. A month outside 1 to 12 or a day of 0 gives range_error with epoch_seconds 0.
// The zone offset register resets to 28800 (eight hours) and is written with cfg_wr_en;
// write it only while no request is in flight.
module calendar_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [6:0]  year_in_century,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] epoch_seconds,
	output logic        range_error
);

	logic [ctes_pkg::ZoneW-1:0] zone_q;

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic ld_s1, ld_s2, ld_s3;

	logic [ctes_pkg::DaysW-1:0]  days_s1;
	logic [ctes_pkg::TodW-1:0]   tod_s1, tod_s2;
	logic                        err_s1, err_s2, err_s3;
	logic [ctes_pkg::EpochW-1:0] prod_s2;
	logic [ctes_pkg::EpochW-1:0] epoch_s3;

	logic [7:0]                  years_from_epoch;
	logic [7:0]                  yic_round;
	logic [5:0]                  leaps_since_base;
	logic                        past_cent;
	logic                        is_leap;
	logic                        feb_done;
	logic                        bad_date;
	logic [ctes_pkg::DaysW-1:0]  days_nxt;
	logic [ctes_pkg::TodW-1:0]   tod_nxt;
	logic [ctes_pkg::DaysW+ctes_pkg::TodW-1:0] prod_full;
	logic [ctes_pkg::EpochW-1:0] zone_ext;
	logic [ctes_pkg::EpochW-1:0] epoch_nxt;

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ctes_pkg::ZoneReset;
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	// pipeline flow control: a stage loads when empty or when its content moves on
	assign adv_s3 = result_ready;
	assign ld_s3  = !v_s3 || adv_s3;
	assign adv_s2 = ld_s3;
	assign ld_s2  = !v_s2 || adv_s2;
	assign adv_s1 = ld_s2;
	assign ld_s1  = !v_s1 || adv_s1;

	assign item_ready = ld_s1;

	// stage 1: range check, day count and time of day
	always_comb begin
		years_from_epoch = ctes_pkg::YearsToBase + {1'b0, year_in_century};
		yic_round        = {1'b0, year_in_century} + 8'd3;
		past_cent        = year_in_century > ctes_pkg::NonLeapCent;
		leaps_since_base = yic_round[7:2] - {5'd0, past_cent};
		is_leap          = (year_in_century[1:0] == 2'b00) &&
			(year_in_century != ctes_pkg::NonLeapCent);
		feb_done         = month > ctes_pkg::MonthFeb;
		bad_date         = (month < ctes_pkg::MonthJan) || (month > ctes_pkg::MonthDec) ||
			(day == 5'd0);
		days_nxt = ({8'd0, years_from_epoch} * 16'd365) + ctes_pkg::LeapsToBase
			+ {10'd0, leaps_since_base}
			+ {7'd0, ctes_pkg::days_before_month(month)}
			+ {15'd0, feb_done && is_leap}
			+ {11'd0, day} - 16'd1;
		tod_nxt = ({12'd0, hour} * 17'd3600) + ({11'd0, minute} * 17'd60)
			+ {11'd0, second};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && item_valid) begin
			days_s1 <= days_nxt;
			tod_s1  <= tod_nxt;
			err_s1  <= bad_date;
		end
	end

	// stage 2: days to seconds
	assign prod_full = {{ctes_pkg::TodW{1'b0}}, days_s1} *
		{{ctes_pkg::DaysW{1'b0}}, ctes_pkg::SecsPerDay};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			prod_s2 <= prod_full[ctes_pkg::EpochW-1:0];
			tod_s2  <= tod_s1;
			err_s2  <= err_s1;
		end
	end

	// stage 3: add time of day, subtract zone offset, zero on a bad date
	assign zone_ext  = {{(ctes_pkg::EpochW-ctes_pkg::ZoneW){zone_q[ctes_pkg::ZoneW-1]}}, zone_q};
	assign epoch_nxt = err_s2 ? '0 :
		(prod_s2 + {{(ctes_pkg::EpochW-ctes_pkg::TodW){1'b0}}, tod_s2} - zone_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && v_s2) begin
			epoch_s3 <= epoch_nxt;
			err_s3   <= err_s2;
		end
	end

	assign result_valid  = v_s3;
	assign epoch_seconds = epoch_s3;
	assign range_error   = err_s3;

`ifndef ASSERT_OFF
	// a flagged result always carries zero seconds
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && err_s3 |-> epoch_s3 == '0)
		else $error("range error result with nonzero seconds");

	// input is held off only when every stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> v_s1 && v_s2 && v_s3)
		else $error("input stalled with a free pipeline stage");

	// a stalled product stage keeps its data
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_s2 |=> v_s2 && $stable(prod_s2) && $stable(tod_s2))
		else $error("stage 2 changed while stalled");

	// range flag moves with its item from stage 1 to stage 2
	a_err_carry: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s1 |=> v_s2 && (err_s2 == $past(err_s1)))
		else $error("range flag lost between stages");
`endif

endmodule

// File: dv/epoch_check_pkg.sv
// reading and result types, calendar predictor and scoreboard for the epoch converter bench
package epoch_check_pkg;

	// one calendar reading as it is offered to the converter
	typedef struct {
		logic [6:0] year_in_century;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} reading_t;

	// one converted result
	typedef struct {
		logic [31:0] epoch;
		logic        range_error;
	} epoch_result_t;

	localparam int unsigned MonthLen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned FirstMonth   = 1;
	localparam int unsigned LastMonth    = 12;
	localparam int unsigned FebMonth     = 2;

	// leap years in [1, y) by the gregorian rule
	function automatic int unsigned leaps_through(input int unsigned y);
		int unsigned p;
		p = y - 1;
		return p / 4 - p / 100 + p / 400;
	endfunction

	class epoch_scoreboard;
		logic signed [16:0] zone_offset;
		epoch_result_t      expected_epochs[$];
		int unsigned        mismatches;
		int unsigned        readings_seen;
		int unsigned        results_checked;
		int unsigned        range_errors_seen;

		function new();
			zone_offset       = ctes_pkg::ZoneReset;
			mismatches        = 0;
			readings_seen     = 0;
			results_checked   = 0;
			range_errors_seen = 0;
		endfunction

		// utc seconds for one reading under the current zone offset
		function epoch_result_t utc_from_reading(input reading_t r);
			epoch_result_t res;
			int unsigned   year;
			int unsigned   days;
			longint        secs;
			res.epoch       = '0;
			res.range_error = 1'b1;
			if (r.month < FirstMonth || r.month > LastMonth || r.day == 0)
				return res;
			year = 2000 + r.year_in_century;
			days = 365 * (year - 1970) + leaps_through(year) - leaps_through(1970);
			for (int m = FirstMonth; m < r.month; m++)
				days += MonthLen[m - 1];
			// february 29 shifts every later month in a leap year
			if (r.month > FebMonth &&
			    (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)))
				days += 1;
			days += r.day - 1;
			secs = longint'(days) * 86400 + longint'(r.hour) * 3600
			     + longint'(r.minute) * 60 + longint'(r.second);
			secs = secs - longint'(zone_offset);
			res.epoch       = secs[31:0];
			res.range_error = 1'b0;
			return res;
		endfunction

		// accepted request: queue what it must produce
		function void note_reading(input reading_t r);
			epoch_result_t res;
			res = utc_from_reading(r);
			if (res.range_error)
				range_errors_seen++;
			expected_epochs.push_back(res);
			readings_seen++;
		endfunction

		task report_mismatch(input string what, input longint unsigned want,
		                     input longint unsigned got);
			$display("tb: mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
			mismatches++;
		endtask

		// accepted result: compare against the oldest pending request
		task check_result(input logic [31:0] epoch, input logic range_error);
			epoch_result_t want;
			results_checked++;
			if (expected_epochs.size() == 0) begin
				report_mismatch("result with no pending request, epoch_seconds", 0, epoch);
				return;
			end
			want = expected_epochs.pop_front();
			if (epoch !== want.epoch)
				report_mismatch("epoch_seconds", want.epoch, epoch);
			if (range_error !== want.range_error)
				report_mismatch("range_error", want.range_error, range_error);
		endtask
	endclass

endpackage

// File: dv/tb_top.sv
// top level bench for the calendar to epoch seconds converter
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned LongHold   = 300;
	localparam int unsigned PhaseItems = 124;

	// zone offsets per phase: -12 h, +14 h, zero, most negative and most positive
	// 17 bit patterns, back to the reset value of +8 h
	localparam logic [16:0] ZoneSettings[6] = '{
		17'h15740, 17'h0C4E0, 17'h00000, 17'h10000, 17'h0FFFF, 17'h07080
	};

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [16:0] cfg_wr_data  = '0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	logic [6:0]  year_in_century = '0;
	logic [3:0]  month        = '0;
	logic [4:0]  day          = '0;
	logic [4:0]  hour         = '0;
	logic [5:0]  minute       = '0;
	logic [5:0]  second       = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] epoch_seconds;
	logic        range_error;

	logic        stall_req    = 1'b0;
	int unsigned cycle_count  = 0;
	int unsigned zones_used   = 1;

	epoch_check_pkg::epoch_scoreboard sb = new();

	calendar_to_epoch_seconds dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.year_in_century (year_in_century),
		.month           (month),
		.day             (day),
		.hour            (hour),
		.minute          (minute),
		.second          (second),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.epoch_seconds   (epoch_seconds),
		.range_error     (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// request and result monitors
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_reading('{year_in_century, month, day, hour, minute, second});
		if (arst_n && result_valid && result_ready)
			sb.check_result(epoch_seconds, range_error);
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		else if (p < 80)
			return $urandom_range(1, 3);
		else if (p < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic epoch_check_pkg::reading_t make_reading(input int unsigned y,
	                                          input int unsigned m,
	                                          input int unsigned d, input int unsigned h,
	                                          input int unsigned mi, input int unsigned s);
		epoch_check_pkg::reading_t r;
		r.year_in_century = 7'(y);
		r.month           = 4'(m);
		r.day             = 5'(d);
		r.hour            = 5'(h);
		r.minute          = 6'(mi);
		r.second          = 6'(s);
		return r;
	endfunction

	// mostly sane calendar readings, with some out of range fields
	function automatic epoch_check_pkg::reading_t random_reading();
		epoch_check_pkg::reading_t r;
		r.year_in_century = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 99))
		                                               : 7'($urandom_range(100, 127));
		if ($urandom_range(0, 9) < 9)
			r.month = 4'($urandom_range(1, 12));
		else
			r.month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
		r.day    = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
		r.hour   = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 23))
		                                      : 5'($urandom_range(0, 31));
		r.minute = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 59))
		                                      : 6'($urandom_range(0, 63));
		r.second = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 59))
		                                      : 6'($urandom_range(0, 63));
		return r;
	endfunction

	// offer one request after an optional gap, hold it until accepted
	task automatic send_reading(input epoch_check_pkg::reading_t r, input int unsigned gap);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid      <= 1'b1;
		year_in_century <= r.year_in_century;
		month           <= r.month;
		day             <= r.day;
		hour            <= r.hour;
		minute          <= r.minute;
		second          <= r.second;
		do @(posedge clk); while (!item_ready);
	endtask

	// stop offering and wait for every pending result
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_epochs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_zone(input logic [16:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en      <= 1'b0;
		sb.zone_offset = value;
		zones_used++;
	endtask

	// random requests, in blocks that are either gapless or gappy
	task automatic send_random(input int unsigned count, input bit steady);
		bit gapless;
		gapless = steady;
		for (int unsigned i = 0; i < count; i++) begin
			if (!steady && i % 32 == 0)
				gapless = ($urandom_range(0, 9) < 3);
			send_reading(random_reading(), gapless ? 0 : pick_gap());
		end
	endtask

	// receiver: stretches of steady ready, short toggles, random stalls
	initial begin
		bit          stall_served;
		int unsigned p;
		stall_served = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			p = $urandom_range(0, 99);
			if (stall_req && !stall_served) begin
				stall_served = 1'b1;
				result_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else if (p < 20) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else if (p < 70) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				result_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed readings under the reset offset
		send_reading(make_reading(0, 1, 1, 0, 0, 0), 0);
		send_reading(make_reading(99, 12, 31, 23, 59, 59), 0);
		// leap day and the day after it
		send_reading(make_reading(24, 2, 29, 12, 0, 0), pick_gap());
		send_reading(make_reading(24, 3, 1, 0, 0, 0), 0);
		// 2000 is a leap year, 2100 is not
		send_reading(make_reading(0, 3, 1, 0, 0, 0), 0);
		send_reading(make_reading(100, 3, 1, 0, 0, 0), pick_gap());
		// all fields at their widest, wrapping past 2^32
		send_reading(make_reading(127, 12, 31, 31, 63, 63), 0);
		// bad month or day
		send_reading(make_reading(10, 0, 15, 1, 2, 3), 0);
		send_reading(make_reading(10, 13, 15, 1, 2, 3), 0);
		send_reading(make_reading(127, 15, 31, 31, 63, 63), pick_gap());
		send_reading(make_reading(50, 6, 0, 4, 5, 6), 0);
		// day past the end of the month
		send_reading(make_reading(23, 2, 31, 0, 0, 0), 0);
		// oversized time of day fields
		send_reading(make_reading(50, 7, 4, 31, 63, 63), 0);
		// each month once
		for (int unsigned m = 1; m <= 12; m++)
			send_reading(make_reading($urandom_range(0, 99), m, 15, 6, 30, 30), pick_gap());
		wait_drained();

		send_random(PhaseItems, 1'b0);
		wait_drained();

		foreach (ZoneSettings[z]) begin
			write_zone(ZoneSettings[z]);
			if (z == 1) begin
				// long output stall while requests keep coming
				stall_req <= 1'b1;
				send_random(PhaseItems / 2, 1'b1);
			end else begin
				send_random(PhaseItems / 2, 1'b0);
			end
			wait_drained();
			send_random(PhaseItems - PhaseItems / 2, 1'b0);
			wait_drained();
		end

		write_zone(17'($urandom));
		send_random(PhaseItems / 2, 1'b0);
		wait_drained();

		repeat (10) @(posedge clk);
		$display("tb: %0d requests checked against %0d results, %0d with range errors",
		         sb.readings_seen, sb.results_checked, sb.range_errors_seen);
		$display("tb: %0d zone offsets used, including both 17 bit extremes; %0d mismatches",
		         zones_used, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
design/ctes_pkg.sv
design/calendar_to_epoch_seconds.sv
dv/epoch_check_pkg.sv
dv/tb_top.sv
